// File: design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types, codes and constants for the deframer and its channels.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4,
    PH_ERR  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_PAY   = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_ERR   = 3'd3,
    KIND_IGN   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_RSV       = 3'd0,
    CAUSE_UNMASKED  = 3'd1,
    CAUSE_OPCODE    = 3'd2,
    CAUSE_CTRL_FRAG = 3'd3,
    CAUSE_CTRL_LONG = 3'd4,
    CAUSE_MSB       = 3'd5,
    CAUSE_OVER      = 3'd6
  } cause_t;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd2097152;
  localparam logic [6:0]  LEN7_EXT16      = 7'd126;
  localparam logic [6:0]  LEN7_EXT64      = 7'd127;
  localparam logic [6:0]  CTRL_MAX_LEN    = 7'd125;
  localparam logic [2:0]  EXT16_LAST      = 3'd1;
  localparam logic [2:0]  EXT64_LAST      = 3'd7;
  localparam logic [2:0]  MASK_LAST       = 3'd3;

  function automatic logic opcode_known(input logic [3:0] op);
    opcode_known = (op <= 4'd2) || ((op >= 4'd8) && (op <= 4'd10));
  endfunction

endpackage

// File: design/wsfd_ifs.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer channels
// Valid/ready request channels for stream bytes in and results out.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       flush;

  modport source (output valid, output data, output flush, input ready);
  modport sink (input valid, input data, input flush, output ready);
endinterface

interface wsfd_out_if;
  import wsfd_pkg::*;

  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       final_fragment;
  logic       last;
  logic [2:0] error_cause;

  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output final_fragment, output last, output error_cause, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                input final_fragment, input last, input error_cause, output ready);
endinterface

// File: design/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a client-to-server WebSocket byte stream and unmasks its payload.
// ----------------------------------------------------------------------------
// The block takes one stream byte per request and returns exactly one result
// per request, so it sustains one byte per cycle unless stalled. Each result
// appears in the output register when its byte is accepted, and a new byte is
// accepted while that result is being taken, since the input is ready whenever
// the output register is empty or being emptied. Header checks are reported on
// the second header byte and length checks when the length field is complete;
// after an error, bytes are ignored until a request with flush set. The
// max_payload register may be written only while no result is pending.
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  wsfd_in_if.sink     in_ch,
  wsfd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import wsfd_pkg::*;

  logic [31:0] max_payload_r;
  phase_t      phase_r, phase_nxt;
  logic        held_fin_r, held_fin_nxt;
  logic [3:0]  held_opcode_r, held_opcode_nxt;
  logic        held_rsv_r, held_rsv_nxt;
  logic        long_len_r, long_len_nxt;
  logic [63:0] length_accum_r, length_accum_nxt;
  logic [2:0]  field_cnt_r, field_cnt_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic [1:0]  mask_index_r, mask_index_nxt;

  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  pb_r, pb_nxt;
  logic [3:0]  opcode_r;
  logic        fin_r;
  logic        last_r, last_nxt;
  logic [2:0]  cause_r, cause_nxt;

  logic        in_fire;
  logic [6:0]  len7;
  logic        hdr_err;
  cause_t      hdr_cause;
  logic [63:0] len_val;
  logic        len_done;
  logic        len_err;
  cause_t      len_cause;
  logic [7:0]  mask_byte;
  logic [31:0] remaining_dec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Header byte 1 checks, lowest cause first.
  assign len7 = in_ch.data[6:0];
  always_comb begin
    hdr_err   = 1'b1;
    hdr_cause = CAUSE_RSV;
    if (held_rsv_r) begin
      hdr_cause = CAUSE_RSV;
    end else if (!in_ch.data[7]) begin
      hdr_cause = CAUSE_UNMASKED;
    end else if (!opcode_known(held_opcode_r)) begin
      hdr_cause = CAUSE_OPCODE;
    end else if (held_opcode_r[3] && !held_fin_r) begin
      hdr_cause = CAUSE_CTRL_FRAG;
    end else if (held_opcode_r[3] && (len7 > CTRL_MAX_LEN)) begin
      hdr_cause = CAUSE_CTRL_LONG;
    end else begin
      hdr_err = 1'b0;
    end
  end

  // Length checks on the short form or on the last extended length byte.
  assign len_val = (phase_r == PH_HDR1) ? {57'd0, len7} : {length_accum_r[55:0], in_ch.data};

  always_comb begin
    len_done = 1'b0;
    case (phase_r)
      PH_HDR1: len_done = !hdr_err && (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64);
      PH_EXT:  len_done = field_cnt_r >= (long_len_r ? EXT64_LAST : EXT16_LAST);
      default: len_done = 1'b0;
    endcase
  end

  always_comb begin
    len_err   = 1'b1;
    len_cause = CAUSE_MSB;
    if (len_val[63]) begin
      len_cause = CAUSE_MSB;
    end else if ((|len_val[62:32]) || (len_val[31:0] > max_payload_r)) begin
      len_cause = CAUSE_OVER;
    end else begin
      len_err = 1'b0;
    end
  end

  assign mask_byte     = 8'(mask_key_r >> {~mask_index_r, 3'b000});
  assign remaining_dec = (remaining_r != 32'd0) ? (remaining_r - 32'd1) : remaining_r;

  // Next frame state.
  always_comb begin
    phase_nxt        = phase_r;
    held_fin_nxt     = held_fin_r;
    held_opcode_nxt  = held_opcode_r;
    held_rsv_nxt     = held_rsv_r;
    long_len_nxt     = long_len_r;
    length_accum_nxt = length_accum_r;
    field_cnt_nxt    = field_cnt_r;
    mask_key_nxt     = mask_key_r;
    remaining_nxt    = remaining_r;
    mask_index_nxt   = mask_index_r;
    if (in_ch.flush) begin
      phase_nxt        = PH_HDR0;
      held_fin_nxt     = 1'b0;
      held_opcode_nxt  = 4'd0;
      held_rsv_nxt     = 1'b0;
      long_len_nxt     = 1'b0;
      length_accum_nxt = 64'd0;
      field_cnt_nxt    = 3'd0;
      mask_key_nxt     = 32'd0;
      remaining_nxt    = 32'd0;
      mask_index_nxt   = 2'd0;
    end else begin
      case (phase_r)
        PH_HDR0: begin
          held_fin_nxt    = in_ch.data[7];
          held_opcode_nxt = in_ch.data[3:0];
          held_rsv_nxt    = |in_ch.data[6:4];
          phase_nxt       = PH_HDR1;
        end
        PH_HDR1: begin
          if (hdr_err) begin
            phase_nxt = PH_ERR;
          end else begin
            length_accum_nxt = len_val;
            field_cnt_nxt    = 3'd0;
            if (!len_done) begin
              length_accum_nxt = 64'd0;
              long_len_nxt     = (len7 == LEN7_EXT64);
              phase_nxt        = PH_EXT;
            end
          end
        end
        PH_EXT: begin
          length_accum_nxt = len_val;
          if (!len_done) begin
            field_cnt_nxt = field_cnt_r + 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_nxt = {mask_key_r[23:0], in_ch.data};
          if (field_cnt_r >= MASK_LAST) begin
            field_cnt_nxt  = 3'd0;
            mask_index_nxt = 2'd0;
            phase_nxt      = (remaining_r == 32'd0) ? PH_HDR0 : PH_PAY;
          end else begin
            field_cnt_nxt = field_cnt_r + 3'd1;
          end
        end
        PH_PAY: begin
          mask_index_nxt = mask_index_r + 2'd1;
          remaining_nxt  = remaining_dec;
          if (remaining_dec == 32'd0) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      if (len_done) begin
        if (len_err) begin
          phase_nxt = PH_ERR;
        end else begin
          remaining_nxt = len_val[31:0];
          field_cnt_nxt = 3'd0;
          mask_key_nxt  = 32'd0;
          phase_nxt     = PH_MASK;
        end
      end
    end
  end

  // Result for the accepted byte.
  always_comb begin
    kind_nxt  = KIND_HDR;
    pb_nxt    = 8'd0;
    last_nxt  = 1'b0;
    cause_nxt = 3'd0;
    if (in_ch.flush) begin
      kind_nxt = KIND_IGN;
    end else begin
      case (phase_r)
        PH_HDR0: begin
          kind_nxt = KIND_HDR;
        end
        PH_HDR1, PH_EXT: begin
          if ((phase_r == PH_HDR1) && hdr_err) begin
            kind_nxt  = KIND_ERR;
            cause_nxt = hdr_cause;
          end else if (len_done && len_err) begin
            kind_nxt  = KIND_ERR;
            cause_nxt = len_cause;
          end
        end
        PH_MASK: begin
          if ((field_cnt_r >= MASK_LAST) && (remaining_r == 32'd0)) begin
            kind_nxt = KIND_EMPTY;
            last_nxt = 1'b1;
          end
        end
        PH_PAY: begin
          kind_nxt = KIND_PAY;
          pb_nxt   = in_ch.data ^ mask_byte;
          last_nxt = (remaining_dec == 32'd0);
        end
        default: begin
          kind_nxt = KIND_IGN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r  <= MAX_PAYLOAD_RST;
      phase_r        <= PH_HDR0;
      held_fin_r     <= 1'b0;
      held_opcode_r  <= 4'd0;
      held_rsv_r     <= 1'b0;
      long_len_r     <= 1'b0;
      length_accum_r <= 64'd0;
      field_cnt_r    <= 3'd0;
      mask_key_r     <= 32'd0;
      remaining_r    <= 32'd0;
      mask_index_r   <= 2'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r        <= phase_nxt;
        held_fin_r     <= held_fin_nxt;
        held_opcode_r  <= held_opcode_nxt;
        held_rsv_r     <= held_rsv_nxt;
        long_len_r     <= long_len_nxt;
        length_accum_r <= length_accum_nxt;
        field_cnt_r    <= field_cnt_nxt;
        mask_key_r     <= mask_key_nxt;
        remaining_r    <= remaining_nxt;
        mask_index_r   <= mask_index_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= kind_nxt;
      pb_r     <= pb_nxt;
      opcode_r <= held_opcode_nxt;
      fin_r    <= held_fin_nxt;
      last_r   <= last_nxt;
      cause_r  <= cause_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.payload_byte   = pb_r;
  assign out_ch.frame_opcode   = opcode_r;
  assign out_ch.final_fragment = fin_r;
  assign out_ch.last           = last_r;
  assign out_ch.error_cause    = cause_r;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends client-to-server byte streams through the request channel: a short
// table of hand-written frames first, then random well-formed frames with
// random content mixed with broken headers and flushes, under four payload
// limits. A behavioral deframer inside the bench predicts the results that the
// table leaves open. Results are checked in order as taken from out_ch.
// ----------------------------------------------------------------------------
module tb_top;
  import wsfd_pkg::*;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    logic [2:0] cause;
  } deframe_result_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            flush;
    logic            typed;
    deframe_result_t want;
  } stim_row_t;

  localparam deframe_result_t UNTYPED = '{KIND_HDR, 8'h00, OP_CONT, 1'b0, 1'b0, 3'd0};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  wsfd_in_if  in_ch ();
  wsfd_out_if out_ch ();

  websocket_frame_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deframer state as seen by the bench.
  phase_t      st_phase;
  logic        cur_fin;
  logic [3:0]  cur_op;
  logic        cur_rsv;
  logic        ext64;
  logic [63:0] len_acc;
  logic [2:0]  fld_cnt;
  logic [31:0] key;
  logic [31:0] left;
  logic [1:0]  key_idx;
  logic [31:0] max_len;

  deframe_result_t pending_results [$];
  int  mismatches = 0;
  int  bytes_sent = 0;
  bit  hold_req = 0;

  stim_row_t opening_rows [23] = '{
    '{8'h00, 1'b1, 1'b1, '{KIND_IGN,  8'h00, OP_CONT, 1'b0, 1'b0, 3'd0}},
    '{8'h81, 1'b0, 1'b1, '{KIND_HDR,  8'h00, OP_TEXT, 1'b1, 1'b0, 3'd0}},
    '{8'h83, 1'b0, 1'b1, '{KIND_HDR,  8'h00, OP_TEXT, 1'b1, 1'b0, 3'd0}},
    '{8'h37, 1'b0, 1'b0, UNTYPED},
    '{8'hFA, 1'b0, 1'b0, UNTYPED},
    '{8'h21, 1'b0, 1'b0, UNTYPED},
    '{8'h3D, 1'b0, 1'b0, UNTYPED},
    '{8'h7F, 1'b0, 1'b1, '{KIND_PAY,  8'h48, OP_TEXT, 1'b1, 1'b0, 3'd0}},
    '{8'h9F, 1'b0, 1'b1, '{KIND_PAY,  8'h65, OP_TEXT, 1'b1, 1'b0, 3'd0}},
    '{8'h4D, 1'b0, 1'b1, '{KIND_PAY,  8'h6C, OP_TEXT, 1'b1, 1'b1, 3'd0}},
    '{8'hF1, 1'b0, 1'b0, UNTYPED},
    '{8'h00, 1'b0, 1'b1, '{KIND_ERR,  8'h00, OP_TEXT, 1'b1, 1'b0, CAUSE_RSV}},
    '{8'hAA, 1'b0, 1'b1, '{KIND_IGN,  8'h00, OP_TEXT, 1'b1, 1'b0, 3'd0}},
    '{8'hFF, 1'b1, 1'b1, '{KIND_IGN,  8'h00, OP_CONT, 1'b0, 1'b0, 3'd0}},
    '{8'h09, 1'b0, 1'b0, UNTYPED},
    '{8'h85, 1'b0, 1'b1, '{KIND_ERR,  8'h00, OP_PING, 1'b0, 1'b0, CAUSE_CTRL_FRAG}},
    '{8'h55, 1'b1, 1'b0, UNTYPED},
    '{8'h8A, 1'b0, 1'b0, UNTYPED},
    '{8'h80, 1'b0, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, 1'b0, UNTYPED},
    '{8'h00, 1'b0, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, 1'b0, UNTYPED},
    '{8'h00, 1'b0, 1'b1, '{KIND_EMPTY, 8'h00, OP_PONG, 1'b1, 1'b1, 3'd0}}
  };

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic clear_frame();
    st_phase = PH_HDR0;
    cur_fin  = 1'b0;
    cur_op   = OP_CONT;
    cur_rsv  = 1'b0;
    ext64    = 1'b0;
    len_acc  = '0;
    fld_cnt  = '0;
    key      = '0;
    left     = '0;
    key_idx  = '0;
  endtask

  task automatic accept_length(output logic bad, output cause_t why);
    bad = 1'b1;
    why = CAUSE_RSV;
    if (len_acc[63]) begin
      why = CAUSE_MSB;
    end else if (len_acc > {32'd0, max_len}) begin
      why = CAUSE_OVER;
    end else begin
      bad      = 1'b0;
      left     = len_acc[31:0];
      fld_cnt  = '0;
      key      = '0;
      st_phase = PH_MASK;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic f,
                              output deframe_result_t r);
    logic [6:0] len7;
    logic       ctrl;
    logic       bad;
    cause_t     why;
    logic [2:0] need;
    r.kind    = KIND_HDR;
    r.payload = '0;
    r.last    = 1'b0;
    r.cause   = '0;
    bad = 1'b0;
    why = CAUSE_RSV;
    if (f) begin
      clear_frame();
      r.kind = KIND_IGN;
    end else begin
      case (st_phase)
        PH_HDR0: begin
          cur_fin  = b[7];
          cur_op   = b[3:0];
          cur_rsv  = |b[6:4];
          st_phase = PH_HDR1;
        end
        PH_HDR1: begin
          len7 = b[6:0];
          ctrl = cur_op >= OP_CLOSE;
          bad  = 1'b1;
          if (cur_rsv) begin
            why = CAUSE_RSV;
          end else if (!b[7]) begin
            why = CAUSE_UNMASKED;
          end else if (!(cur_op <= OP_BINARY || (cur_op >= OP_CLOSE && cur_op <= OP_PONG))) begin
            why = CAUSE_OPCODE;
          end else if (ctrl && !cur_fin) begin
            why = CAUSE_CTRL_FRAG;
          end else if (ctrl && len7 > CTRL_MAX_LEN) begin
            why = CAUSE_CTRL_LONG;
          end else begin
            bad     = 1'b0;
            len_acc = '0;
            fld_cnt = '0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
              ext64    = (len7 == LEN7_EXT64);
              st_phase = PH_EXT;
            end else begin
              len_acc = {57'd0, len7};
              accept_length(bad, why);
            end
          end
        end
        PH_EXT: begin
          need    = ext64 ? EXT64_LAST : EXT16_LAST;
          len_acc = {len_acc[55:0], b};
          if (fld_cnt >= need) accept_length(bad, why);
          else fld_cnt = fld_cnt + 3'd1;
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (fld_cnt >= MASK_LAST) begin
            fld_cnt = '0;
            key_idx = '0;
            if (left == 0) begin
              st_phase = PH_HDR0;
              r.kind   = KIND_EMPTY;
              r.last   = 1'b1;
            end else begin
              st_phase = PH_PAY;
            end
          end else begin
            fld_cnt = fld_cnt + 3'd1;
          end
        end
        PH_PAY: begin
          r.kind    = KIND_PAY;
          r.payload = b ^ 8'(key >> (24 - 8 * key_idx));
          key_idx   = key_idx + 2'd1;
          if (left > 0) left = left - 32'd1;
          if (left == 0) begin
            r.last   = 1'b1;
            st_phase = PH_HDR0;
          end
        end
        default: r.kind = KIND_IGN;
      endcase
    end
    if (bad) begin
      st_phase = PH_ERR;
      r.kind   = KIND_ERR;
      r.cause  = why;
    end
    r.opcode = cur_op;
    r.fin    = cur_fin;
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic f, output deframe_result_t r);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    in_ch.flush <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deframe_byte(b, f, r);
    bytes_sent++;
  endtask

  task automatic idle_after(input bit fast);
    int gap;
    gap = fast ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic queue_result(input deframe_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic f, input bit fast);
    deframe_result_t r;
    offer_byte(b, f, r);
    queue_result(r);
    idle_after(fast);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [31:0] value);
    drain();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_len = value;
  endtask

  task automatic send_frame(input bit fast);
    logic [3:0]  op;
    logic        fin;
    logic [63:0] len;
    logic [6:0]  len7;
    int          mode;
    int          sent;
    case ($urandom_range(0, 5))
      0: op = OP_CONT;
      1: op = OP_TEXT;
      2: op = OP_BINARY;
      3: op = OP_CLOSE;
      4: op = OP_PING;
      default: op = OP_PONG;
    endcase
    fin = (op >= OP_CLOSE) ? 1'b1 : 1'($urandom_range(0, 1));
    len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 300)) : 64'($urandom_range(0, 12));
    if ($urandom_range(0, 15) == 0) len = {$urandom, $urandom};
    else if (max_len == '1 && $urandom_range(0, 7) == 0) len = {32'd0, $urandom};
    mode = $urandom_range(0, 2);
    if (op >= OP_CLOSE) begin
      mode = 0;
      len  = len % 126;
    end
    if (mode == 0 && len > 125) mode = 1;
    if (mode == 1 && len > 65535) mode = 2;
    len7 = (mode == 0) ? len[6:0] : (mode == 1) ? LEN7_EXT16 : LEN7_EXT64;
    send_byte({fin, 3'b000, op}, 1'b0, fast);
    send_byte({1'b1, len7}, 1'b0, fast);
    if (mode == 1) for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0, fast);
    if (mode == 2) for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0, fast);
    if (st_phase == PH_MASK) repeat (4) send_byte(8'($urandom), 1'b0, fast);
    sent = 0;
    while (st_phase == PH_PAY) begin
      send_byte(8'($urandom), ($urandom_range(0, 63) == 0 || sent > 400), fast);
      sent++;
    end
    if (st_phase != PH_HDR0) send_byte(8'($urandom), 1'b1, fast);
  endtask

  task automatic send_noise(input bit fast);
    logic [7:0] h0;
    logic [7:0] h1;
    int         n;
    h0 = 8'($urandom);
    if ($urandom_range(0, 1)) h0[6:4] = 3'b000;
    h1 = 8'($urandom);
    if ($urandom_range(0, 3) != 0) h1[7] = 1'b1;
    if ($urandom_range(0, 2) == 0) h1[6:0] = $urandom_range(0, 1) ? LEN7_EXT64 : LEN7_EXT16;
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b1, fast);
    send_byte(h0, 1'b0, fast);
    send_byte(h1, 1'b0, fast);
    n = $urandom_range(0, 12);
    repeat (n) send_byte(8'($urandom), 1'b0, fast);
    if (st_phase != PH_HDR0) send_byte(8'($urandom), 1'b1, fast);
  endtask

  task automatic run_traffic(input int count);
    int target;
    bit fast;
    target = bytes_sent + count;
    hold_req = 1'b1;
    repeat (3) send_frame(1'b1);
    while (bytes_sent < target) begin
      fast = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) send_noise(fast);
      else send_frame(fast);
      if ($urandom_range(0, 60) == 0) drain();
    end
    drain();
  endtask

  initial begin
    deframe_result_t r;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    in_ch.flush <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    clear_frame();
    max_len = MAX_PAYLOAD_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      offer_byte(opening_rows[i].data, opening_rows[i].flush, r);
      queue_result(opening_rows[i].typed ? opening_rows[i].want : r);
      idle_after(1'b0);
    end

    run_traffic(600);
    set_max_payload(32'd0);
    run_traffic(300);
    set_max_payload(32'hFFFF_FFFF);
    run_traffic(400);
    set_max_payload(32'($urandom_range(8, 64)));
    run_traffic(600);

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("** websocket_frame_deframer_top: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: unexpected result, expected none, got kind=%0d byte=%h", $time,
                   out_ch.kind, out_ch.payload_byte);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind || out_ch.payload_byte !== want.payload ||
            out_ch.frame_opcode !== want.opcode || out_ch.final_fragment !== want.fin ||
            out_ch.last !== want.last || out_ch.error_cause !== want.cause) begin
          mismatches++;
          if (mismatches <= 50) begin
            $display("%0t: expected kind=%0d byte=%h op=%h fin=%b last=%b cause=%0d", $time,
                     want.kind, want.payload, want.opcode, want.fin, want.last, want.cause);
            $display("%0t: actual   kind=%0d byte=%h op=%h fin=%b last=%b cause=%0d", $time,
                     out_ch.kind, out_ch.payload_byte, out_ch.frame_opcode,
                     out_ch.final_fragment, out_ch.last, out_ch.error_cause);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** websocket_frame_deframer_top: FAILED **");
    $finish;
  end

endmodule
